// ----- rtl/core/tcpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP connection state machine package
// Shared types, state codes and sequence helpers.
// ----------------------------------------------------------------------------
package tcpsm_pkg;

   localparam logic [3:0] ST_CLOSED    = 4'd0;
   localparam logic [3:0] ST_LISTEN    = 4'd1;
   localparam logic [3:0] ST_SYN_SENT  = 4'd2;
   localparam logic [3:0] ST_SYN_RCVD  = 4'd3;
   localparam logic [3:0] ST_ESTAB     = 4'd4;
   localparam logic [3:0] ST_FINW1     = 4'd5;
   localparam logic [3:0] ST_FINW2     = 4'd6;
   localparam logic [3:0] ST_CLOSEWAIT = 4'd7;
   localparam logic [3:0] ST_CLOSING   = 4'd8;
   localparam logic [3:0] ST_LASTACK   = 4'd9;
   localparam logic [3:0] ST_TIMEWAIT  = 4'd10;

   localparam logic [2:0] CMD_SEGMENT = 3'd0;
   localparam logic [2:0] CMD_LISTEN  = 3'd1;
   localparam logic [2:0] CMD_CONNECT = 3'd2;
   localparam logic [2:0] CMD_CLOSE   = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;
   localparam logic [2:0] CMD_TW_EXP  = 3'd5;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_CLOSING = 2'd2;
   localparam logic [1:0] STS_GRANT   = 2'd3;

   localparam logic [15:0] RBS_RESET = 16'd4096;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [15:0] payload_len;
      logic [15:0] seg_window;
      logic        flag_syn;
      logic        flag_ack;
      logic        flag_fin;
      logic        flag_rst;
      logic [31:0] initial_seq;
      logic [15:0] read_len;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [31:0] out_seq;
      logic [31:0] out_ack;
      logic        out_syn;
      logic        out_ack_flag;
      logic        out_fin;
      logic        out_rst;
      logic [15:0] out_window;
      logic [3:0]  conn_state;
      logic [1:0]  status;
      logic [15:0] grant_len;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  state_code;
      logic [31:0] send_unacked;
      logic [31:0] send_next;
      logic [15:0] send_window;
      logic [31:0] window_update_seq;
      logic [31:0] window_update_ack;
      logic [31:0] recv_next;
      logic [15:0] recv_window;
      logic [31:0] initial_send_seq;
      logic [31:0] initial_recv_seq;
   } conn_type;

   function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
      return !seq_lt(b, a);
   endfunction

endpackage

// ----- rtl/core/tcpsm_if.sv -----
// ----------------------------------------------------------------------------
// TCP connection state machine channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tcpsm_req_if;
   logic                 valid;
   logic                 ready;
   tcpsm_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tcpsm_rsp_if;
   logic                 valid;
   logic                 ready;
   tcpsm_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tcpsm_eval.sv -----
// ----------------------------------------------------------------------------
// TCP connection state machine evaluation
// Computes the next connection state and up to two results for one request.
// ----------------------------------------------------------------------------
module tcpsm_eval (
   input  tcpsm_pkg::conn_type cur,
   input  tcpsm_pkg::req_type  rq,
   input  logic [15:0]         rbs,
   output tcpsm_pkg::conn_type nxt,
   output tcpsm_pkg::rsp_type  res0,
   output tcpsm_pkg::rsp_type  res1,
   output logic                two
);

   tcpsm_pkg::rsp_type h0, h1, hx;
   logic [1:0]  npend;
   logic [1:0]  status;
   logic [15:0] grant;
   logic [31:0] slen, off, offe;
   logic [15:0] held, take;
   logic        acc, cut, done;

   always_comb begin
      nxt    = cur;
      h0     = '0;
      h1     = '0;
      hx     = '0;
      npend  = 2'd0;
      status = tcpsm_pkg::STS_OK;
      grant  = 16'd0;
      acc    = 1'b0;
      cut    = 1'b0;
      done   = 1'b0;
      take   = 16'd0;
      held   = (rbs > cur.recv_window) ? rbs - cur.recv_window : 16'd0;
      slen   = {16'd0, rq.payload_len} + {31'd0, rq.flag_syn} + {31'd0, rq.flag_fin};
      off    = rq.seg_seq - cur.recv_next;
      offe   = off + slen - 32'd1;
      unique case (rq.cmd)
         tcpsm_pkg::CMD_SEGMENT: begin
            if (cur.state_code == tcpsm_pkg::ST_CLOSED) begin
               if (!rq.flag_rst) begin
                  npend = 2'd1;
                  h0.send_valid = 1'b1;
                  h0.out_rst = 1'b1;
                  if (!rq.flag_ack) begin
                     h0.out_ack = rq.seg_seq + slen;
                     h0.out_ack_flag = 1'b1;
                  end else begin
                     h0.out_seq = rq.seg_ack;
                  end
               end
            end else if (cur.state_code == tcpsm_pkg::ST_LISTEN) begin
               if (!rq.flag_rst) begin
                  if (rq.flag_ack) begin
                     npend = 2'd1;
                     h0.send_valid = 1'b1;
                     h0.out_rst = 1'b1;
                     h0.out_seq = rq.seg_ack;
                  end else if (rq.flag_syn) begin
                     nxt.recv_window = rbs;
                     nxt.recv_next = rq.seg_seq + 32'd1;
                     nxt.initial_recv_seq = rq.seg_seq;
                     nxt.initial_send_seq = rq.initial_seq;
                     nxt.send_unacked = rq.initial_seq;
                     nxt.send_next = rq.initial_seq + 32'd1;
                     nxt.send_window = 16'd0;
                     nxt.window_update_seq = 32'd0;
                     nxt.window_update_ack = 32'd0;
                     npend = 2'd1;
                     h0.send_valid = 1'b1;
                     h0.out_syn = 1'b1;
                     h0.out_ack_flag = 1'b1;
                     h0.out_seq = rq.initial_seq;
                     h0.out_ack = rq.seg_seq + 32'd1;
                     h0.out_window = rbs;
                     nxt.state_code = tcpsm_pkg::ST_SYN_RCVD;
                  end
               end
            end else if (cur.state_code == tcpsm_pkg::ST_SYN_SENT) begin
               if (rq.flag_ack) begin
                  if (tcpsm_pkg::seq_le(rq.seg_ack, cur.initial_send_seq) ||
                      tcpsm_pkg::seq_lt(cur.send_next, rq.seg_ack)) begin
                     done = 1'b1;
                     if (!rq.flag_rst) begin
                        npend = 2'd1;
                        h0.send_valid = 1'b1;
                        h0.out_rst = 1'b1;
                        h0.out_seq = rq.seg_ack;
                     end
                  end else begin
                     acc = tcpsm_pkg::seq_le(cur.send_unacked, rq.seg_ack) &&
                           tcpsm_pkg::seq_le(rq.seg_ack, cur.send_next);
                  end
               end
               if (!done) begin
                  if (rq.flag_rst) begin
                     if (acc) nxt.state_code = tcpsm_pkg::ST_CLOSED;
                  end else if (rq.flag_syn) begin
                     nxt.recv_next = rq.seg_seq + 32'd1;
                     nxt.initial_recv_seq = rq.seg_seq;
                     if (acc) nxt.send_unacked = rq.seg_ack;
                     npend = 2'd1;
                     h0.send_valid = 1'b1;
                     h0.out_ack_flag = 1'b1;
                     h0.out_ack = rq.seg_seq + 32'd1;
                     h0.out_window = cur.recv_window;
                     if (tcpsm_pkg::seq_lt(cur.initial_send_seq, nxt.send_unacked)) begin
                        nxt.state_code = tcpsm_pkg::ST_ESTAB;
                        h0.out_seq = cur.send_next;
                        nxt.send_window = rq.seg_window;
                        nxt.window_update_seq = rq.seg_seq;
                        nxt.window_update_ack = rq.seg_ack;
                     end else begin
                        nxt.state_code = tcpsm_pkg::ST_SYN_RCVD;
                        h0.out_syn = 1'b1;
                        h0.out_seq = cur.initial_send_seq;
                     end
                  end
               end
            end else begin
               if (slen == 32'd0) begin
                  acc = (cur.recv_window == 16'd0) ? (rq.seg_seq == cur.recv_next) :
                        (off < {16'd0, cur.recv_window});
               end else begin
                  acc = (cur.recv_window != 16'd0) &&
                        ((off < {16'd0, cur.recv_window}) ||
                         (offe < {16'd0, cur.recv_window}));
               end
               hx.send_valid = 1'b1;
               hx.out_ack_flag = 1'b1;
               hx.out_seq = cur.send_next;
               hx.out_ack = cur.recv_next;
               hx.out_window = cur.recv_window;
               if (!acc) begin
                  if (!rq.flag_rst) begin
                     npend = 2'd1;
                     h0 = hx;
                  end
               end else if (rq.flag_rst) begin
                  nxt.state_code = tcpsm_pkg::ST_CLOSED;
               end else if (rq.flag_syn) begin
                  npend = 2'd1;
                  h0 = hx;
                  h0.out_ack_flag = 1'b0;
                  h0.out_rst = 1'b1;
                  nxt.state_code = tcpsm_pkg::ST_CLOSED;
               end else if (rq.flag_ack) begin
                  if (cur.state_code == tcpsm_pkg::ST_SYN_RCVD) begin
                     if (tcpsm_pkg::seq_le(cur.send_unacked, rq.seg_ack) &&
                         tcpsm_pkg::seq_le(rq.seg_ack, cur.send_next)) begin
                        nxt.state_code = tcpsm_pkg::ST_ESTAB;
                     end else begin
                        done = 1'b1;
                        npend = 2'd1;
                        h0.send_valid = 1'b1;
                        h0.out_rst = 1'b1;
                        h0.out_seq = rq.seg_ack;
                     end
                  end
                  if (!done && nxt.state_code == tcpsm_pkg::ST_LASTACK) begin
                     done = 1'b1;
                     if (rq.seg_ack == cur.send_next) nxt.state_code = tcpsm_pkg::ST_CLOSED;
                  end
                  if (!done && nxt.state_code >= tcpsm_pkg::ST_ESTAB &&
                      nxt.state_code <= tcpsm_pkg::ST_CLOSING) begin
                     if (tcpsm_pkg::seq_lt(cur.send_unacked, rq.seg_ack) &&
                         tcpsm_pkg::seq_le(rq.seg_ack, cur.send_next)) begin
                        nxt.send_unacked = rq.seg_ack;
                        if (tcpsm_pkg::seq_lt(cur.window_update_seq, rq.seg_seq) ||
                            (cur.window_update_seq == rq.seg_seq &&
                             tcpsm_pkg::seq_le(cur.window_update_ack, rq.seg_ack))) begin
                           nxt.send_window = rq.seg_window;
                           nxt.window_update_seq = rq.seg_seq;
                           nxt.window_update_ack = rq.seg_ack;
                        end
                     end else if (tcpsm_pkg::seq_lt(cur.send_next, rq.seg_ack) &&
                                  !tcpsm_pkg::seq_lt(rq.seg_ack, cur.send_unacked)) begin
                        done = 1'b1;
                        npend = 2'd1;
                        h0 = hx;
                     end
                     if (!done) begin
                        if (nxt.state_code == tcpsm_pkg::ST_FINW1 &&
                            rq.seg_ack == cur.send_next) begin
                           nxt.state_code = tcpsm_pkg::ST_FINW2;
                        end else if (nxt.state_code == tcpsm_pkg::ST_CLOSING &&
                                     rq.seg_ack == cur.send_next) begin
                           nxt.state_code = tcpsm_pkg::ST_TIMEWAIT;
                        end
                     end
                  end
                  if (!done) begin
                     if ((nxt.state_code == tcpsm_pkg::ST_ESTAB ||
                          nxt.state_code == tcpsm_pkg::ST_FINW1 ||
                          nxt.state_code == tcpsm_pkg::ST_FINW2) &&
                         rq.payload_len != 16'd0) begin
                        take = (rq.payload_len < cur.recv_window) ? rq.payload_len :
                               cur.recv_window;
                        cut = take < rq.payload_len;
                        nxt.recv_next = rq.seg_seq + {16'd0, take};
                        nxt.recv_window = cur.recv_window - take;
                        npend = 2'd1;
                        h0 = hx;
                        h0.out_ack = nxt.recv_next;
                        h0.out_window = nxt.recv_window;
                     end
                     if (rq.flag_fin && !cut && nxt.state_code >= tcpsm_pkg::ST_SYN_RCVD) begin
                        nxt.recv_next = rq.seg_seq + {16'd0, rq.payload_len} + 32'd1;
                        if (npend == 2'd0) begin
                           h0 = hx;
                           h0.out_ack = nxt.recv_next;
                           h0.out_window = nxt.recv_window;
                        end else begin
                           h1 = hx;
                           h1.out_ack = nxt.recv_next;
                           h1.out_window = nxt.recv_window;
                        end
                        npend = npend + 2'd1;
                        if (nxt.state_code == tcpsm_pkg::ST_ESTAB) begin
                           nxt.state_code = tcpsm_pkg::ST_CLOSEWAIT;
                        end else if (nxt.state_code == tcpsm_pkg::ST_FINW1) begin
                           nxt.state_code = (rq.seg_ack == cur.send_next) ?
                                            tcpsm_pkg::ST_TIMEWAIT : tcpsm_pkg::ST_CLOSING;
                        end else if (nxt.state_code == tcpsm_pkg::ST_FINW2) begin
                           nxt.state_code = tcpsm_pkg::ST_TIMEWAIT;
                        end
                     end
                  end
               end
            end
         end
         tcpsm_pkg::CMD_LISTEN: begin
            if (cur.state_code == tcpsm_pkg::ST_CLOSED || cur.state_code == tcpsm_pkg::ST_LISTEN)
               nxt.state_code = tcpsm_pkg::ST_LISTEN;
            else
               status = tcpsm_pkg::STS_INVALID;
         end
         tcpsm_pkg::CMD_CONNECT: begin
            if (cur.state_code == tcpsm_pkg::ST_CLOSED ||
                cur.state_code == tcpsm_pkg::ST_LISTEN) begin
               nxt.recv_window = rbs;
               nxt.recv_next = 32'd0;
               nxt.initial_recv_seq = 32'd0;
               nxt.initial_send_seq = rq.initial_seq;
               nxt.send_unacked = rq.initial_seq;
               nxt.send_next = rq.initial_seq + 32'd1;
               nxt.send_window = 16'd0;
               nxt.window_update_seq = 32'd0;
               nxt.window_update_ack = 32'd0;
               npend = 2'd1;
               h0.send_valid = 1'b1;
               h0.out_syn = 1'b1;
               h0.out_seq = rq.initial_seq;
               h0.out_window = rbs;
               nxt.state_code = tcpsm_pkg::ST_SYN_SENT;
            end else begin
               status = tcpsm_pkg::STS_INVALID;
            end
         end
         tcpsm_pkg::CMD_CLOSE: begin
            if (cur.state_code == tcpsm_pkg::ST_CLOSED) begin
               status = tcpsm_pkg::STS_INVALID;
            end else if (cur.state_code == tcpsm_pkg::ST_LISTEN ||
                         cur.state_code == tcpsm_pkg::ST_SYN_SENT) begin
               nxt.state_code = tcpsm_pkg::ST_CLOSED;
            end else if (cur.state_code == tcpsm_pkg::ST_SYN_RCVD ||
                         cur.state_code == tcpsm_pkg::ST_ESTAB ||
                         cur.state_code == tcpsm_pkg::ST_CLOSEWAIT) begin
               npend = 2'd1;
               h0.send_valid = 1'b1;
               h0.out_fin = 1'b1;
               h0.out_ack_flag = 1'b1;
               h0.out_seq = cur.send_next;
               h0.out_ack = cur.recv_next;
               h0.out_window = cur.recv_window;
               nxt.send_next = cur.send_next + 32'd1;
               nxt.state_code = (cur.state_code == tcpsm_pkg::ST_CLOSEWAIT) ?
                                tcpsm_pkg::ST_LASTACK : tcpsm_pkg::ST_FINW1;
            end else begin
               status = tcpsm_pkg::STS_CLOSING;
            end
         end
         tcpsm_pkg::CMD_READ: begin
            if (cur.state_code <= tcpsm_pkg::ST_SYN_RCVD) begin
               status = tcpsm_pkg::STS_INVALID;
            end else if (cur.state_code <= tcpsm_pkg::ST_FINW2 ||
                         (cur.state_code == tcpsm_pkg::ST_CLOSEWAIT && held != 16'd0)) begin
               grant = (rq.read_len < held) ? rq.read_len : held;
               nxt.recv_window = cur.recv_window + grant;
               status = tcpsm_pkg::STS_GRANT;
            end else begin
               status = tcpsm_pkg::STS_CLOSING;
            end
         end
         tcpsm_pkg::CMD_TW_EXP: begin
            if (cur.state_code == tcpsm_pkg::ST_TIMEWAIT)
               nxt.state_code = tcpsm_pkg::ST_CLOSED;
            else
               status = tcpsm_pkg::STS_INVALID;
         end
         default: begin
            status = tcpsm_pkg::STS_INVALID;
         end
      endcase

      res0 = h0;
      res0.conn_state = nxt.state_code;
      res0.status = status;
      res0.grant_len = grant;
      res0.last = (npend != 2'd2);
      res1 = h1;
      res1.conn_state = nxt.state_code;
      res1.status = status;
      res1.grant_len = grant;
      res1.last = 1'b1;
      two = (npend == 2'd2);
   end

endmodule

// ----- rtl/core/tcp_connection_state_machine.sv -----
// ----------------------------------------------------------------------------
// TCP connection state machine
// Control state of one TCP connection with an APB register port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Contents
//  req_ch    in         valid/ready       segment header or local command
//  rsp_ch    out        valid/ready       header to send, state, status
//  csr_*     in/out     APB, pready = 1   receive_buffer_size at address 0
//
// A request is registered, evaluated against the connection state and
// written into the result register, so one request per cycle is taken
// when each yields one result; a request that yields two results holds
// the result register until both are taken. Reset is synchronous and
// clears the connection state and the valid flags. A stalled result
// channel stops evaluation, and the input register then holds its request.
// ----------------------------------------------------------------------------
module tcp_connection_state_machine (
   input  logic              clock,
   input  logic              reset,
   tcpsm_req_if.sink         req_ch,
   tcpsm_rsp_if.source       rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   tcpsm_pkg::conn_type conn_ff, conn_in;
   tcpsm_pkg::req_type  req_ff;
   tcpsm_pkg::rsp_type  res0_ff, res1_ff, res0_in, res1_in;
   logic [15:0] rbs_ff;
   logic        in_valid_ff, out_valid_ff, out_two_ff, out_sel_ff, two_in;
   logic        out_free, fire, req_take;

   tcpsm_eval u_eval (
      .cur  (conn_ff),
      .rq   (req_ff),
      .rbs  (rbs_ff),
      .nxt  (conn_in),
      .res0 (res0_in),
      .res1 (res1_in),
      .two  (two_in)
   );

   assign out_free   = !out_valid_ff || (rsp_ch.ready && (out_sel_ff || !out_two_ff));
   assign fire       = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_take   = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_sel_ff ? res1_ff : res0_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'd0, rbs_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rbs_ff       <= tcpsm_pkg::RBS_RESET;
         conn_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_two_ff   <= 1'b0;
         out_sel_ff   <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0)
            rbs_ff <= csr_pwdata[15:0];
         if (req_take)
            in_valid_ff <= 1'b1;
         else if (fire)
            in_valid_ff <= 1'b0;
         if (fire) begin
            conn_ff      <= conn_in;
            out_valid_ff <= 1'b1;
            out_two_ff   <= two_in;
            out_sel_ff   <= 1'b0;
         end else if (out_valid_ff && rsp_ch.ready) begin
            if (!out_sel_ff && out_two_ff) begin
               out_sel_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b0;
               out_sel_ff   <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         req_ff <= req_ch.payload;
      if (fire) begin
         res0_ff <= res0_in;
         res1_ff <= res1_in;
      end
   end

   a_sel_two: assert property (@(posedge clock) disable iff (reset)
      out_sel_ff |-> (out_two_ff && out_valid_ff))
      else $error("second result selected without a pair pending");
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("evaluated request produced no result");
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("pending request lost");

endmodule
